[rtl/core/utlc_pkg.sv]
// ----------------------------------------------------------------------------
// utlc_pkg
// Shared types, constants and calendar helpers for the time-to-calendar block.
// ----------------------------------------------------------------------------
`default_nettype none

package utlc_pkg;

  typedef logic [7:0]  yoff_t;   // years since 1970
  typedef logic [15:0] days_t;   // whole days since 1970-01-01
  typedef logic [8:0]  doy_t;    // day of year, 0 based

  localparam logic REG_ZONE = 1'b0;            // register index of the zone offset
  localparam logic [4:0] ZONE_RESET = 5'd8;

  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  // days = (local >> 7) / 675, exact for 26-bit dividends
  localparam int unsigned DAY_SHIFT = 36;
  localparam logic [9:0]  DAY_DIV_HI = 10'd675;
  localparam logic [26:0] DAY_RECIP = 27'((64'd1 << DAY_SHIFT) / 64'd675 + 64'd1);

  // year estimate = days * 4 / 1461, may fall one short
  localparam logic [15:0] YEAR_RECIP = 16'((64'd1 << 26) / 64'd1461);

  // hour = (sod >> 4) / 225
  localparam logic [13:0] HOUR_RECIP = 14'((32'd1 << 21) / 32'd225 + 32'd1);

  // minute = (rem >> 2) / 15
  localparam logic [10:0] MIN_RECIP = 11'((32'd1 << 14) / 32'd15 + 32'd1);

  localparam logic [11:0] FIRST_YEAR = 12'd1970;
  localparam yoff_t YEAR_2100 = 8'd130;        // century year that is not leap

  // first day (since 1970) of year 1970 + n
  function automatic days_t year_start(input yoff_t n);
    logic [8:0]  n1;
    logic [16:0] acc;
    n1  = {1'b0, n} + 9'd1;
    acc = 17'(n) * 17'd365 + 17'(n1 >> 2);
    if (n > YEAR_2100) begin
      acc = acc - 17'd1;
    end
    return acc[15:0];
  endfunction

  function automatic logic yr_leap(input yoff_t n);
    return (n[1:0] == 2'd2) && (n != YEAR_2100);
  endfunction

  // day of year on which month idx (0 is january) begins
  function automatic doy_t month_start(input logic [3:0] idx, input logic leap);
    doy_t base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

[rtl/core/utlc_month.sv]
// ----------------------------------------------------------------------------
// utlc_month
// Splits a day of year into month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module utlc_month
  import utlc_pkg::*;
(
  input  doy_t       doy,
  input  logic       leap,
  output logic [3:0] month,
  output logic [4:0] day
);

  logic [3:0] cnt;
  doy_t       offs;

  // month boundaries are monotone, so the count of passed ones is the index
  always_comb begin
    cnt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy >= month_start(4'(m), leap)) begin
        cnt = cnt + 4'd1;
      end
    end
  end

  assign offs  = doy - month_start(cnt, leap);
  assign month = cnt + 4'd1;
  assign day   = offs[4:0] + 5'd1;

endmodule

`default_nettype wire

[rtl/core/unix_time_to_local_calendar.sv]
// ----------------------------------------------------------------------------
// unix_time_to_local_calendar
// Unix timestamp to local Gregorian date and time with a whole-hour zone.
// ----------------------------------------------------------------------------
// usage
//   input channel  : timestamp with in_valid / in_ready, one word per item
//   output channel : year, month, day, hour, minute, second, out_of_range
//                    with out_valid / out_ready, one word per input word
//   apb port       : register 0 (byte address 0) holds zone_offset_hours,
//                    5-bit two's complement, reset 8; write only while idle
// timing
//   seven register stages; an accepted word moves through them in order into
//   the output register, waiting in any stage whose successor is still full
//   one word per cycle sustained while out_ready is high; every stage takes
//   a new word as soon as it is empty or its word moves on, so bubbles close up under a stall
//   the critical stage holds the 26 x 27 reciprocal multiply for day split
// reset
//   rst is synchronous; it empties the pipeline and loads the zone with 8
// stall
//   a low out_ready freezes the output word; upstream stages keep filling
//   until the pipeline is full, then in_ready drops
// out_of_range is set with all other fields zero when local time is before
// the epoch
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_local_calendar
  import utlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [31:0] timestamp,
  // output channel
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [11:0] year,
  output      logic [3:0]  month,
  output      logic [4:0]  day,
  output      logic [4:0]  hour,
  output      logic [5:0]  minute,
  output      logic [5:0]  second,
  output      logic        out_of_range
);

  localparam int unsigned STAGES = 7;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [4:0] zone;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = {27'd0, zone};

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= ZONE_RESET;
    end else if (cfg_wr && (paddr[2] == REG_ZONE)) begin
      zone <= pwdata[4:0];
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage advances when empty or when its word leaves
  // --------------------------------------------------------------------------
  logic [STAGES:1] vld;
  logic [STAGES:1] adv;

  always_comb begin
    adv[STAGES] = !vld[STAGES] || out_ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: apply zone offset, local seconds as 34-bit two's complement
  // --------------------------------------------------------------------------
  logic signed [16:0] zone_sec;
  logic [33:0]        loc_next;
  logic [33:0]        s1_loc;

  assign zone_sec = $signed({{12{zone[4]}}, zone}) * $signed(17'(SECS_PER_HOUR));
  assign loc_next = {2'b00, timestamp} + {{17{zone_sec[16]}}, zone_sec};

  // --------------------------------------------------------------------------
  // stage 2: day quotient by reciprocal multiply (86400 = 675 << 7)
  // --------------------------------------------------------------------------
  logic [52:0] prod_next;
  logic [52:0] s2_prod;
  logic [25:0] s2_hi;
  logic [6:0]  s2_lo;
  logic        s2_neg;

  assign prod_next = 53'(s1_loc[32:7]) * 53'(DAY_RECIP);

  // --------------------------------------------------------------------------
  // stage 3: day count, seconds of day, rough year estimate
  // --------------------------------------------------------------------------
  days_t       days_c;
  logic [25:0] rem_hi;
  logic [31:0] est_prod;
  days_t       s3_days;
  logic [16:0] s3_sod;
  yoff_t       s3_est;
  logic        s3_neg;

  assign days_c   = s2_prod[DAY_SHIFT+15:DAY_SHIFT];
  assign rem_hi   = s2_hi - 26'(days_c) * 26'(DAY_DIV_HI);
  assign est_prod = 32'(days_c) * 32'(YEAR_RECIP);

  // --------------------------------------------------------------------------
  // stage 4: settle the year (estimate may be one low), day of year, hour mul
  // --------------------------------------------------------------------------
  yoff_t       est_up;
  days_t       st_lo;
  days_t       st_hi;
  logic        take_hi;
  yoff_t       n_c;
  days_t       doy_wide;
  logic [26:0] hprod_c;
  yoff_t       s4_n;
  doy_t        s4_doy;
  logic        s4_leap;
  logic [16:0] s4_sod;
  logic [26:0] s4_hprod;
  logic        s4_neg;

  assign est_up   = s3_est + 8'd1;
  assign st_lo    = year_start(s3_est);
  assign st_hi    = year_start(est_up);
  assign take_hi  = (s3_days >= st_hi);
  assign n_c      = take_hi ? est_up : s3_est;
  assign doy_wide = s3_days - (take_hi ? st_hi : st_lo);
  assign hprod_c  = 27'(s3_sod[16:4]) * 27'(HOUR_RECIP);

  // --------------------------------------------------------------------------
  // stage 5: month and day, hour, seconds left in the hour
  // --------------------------------------------------------------------------
  logic [3:0]  month_c;
  logic [4:0]  day_c;
  logic [4:0]  hour_c;
  logic [16:0] rem_wide;
  logic [11:0] s5_year;
  logic [3:0]  s5_month;
  logic [4:0]  s5_day;
  logic [4:0]  s5_hour;
  logic [11:0] s5_rem;
  logic        s5_neg;

  utlc_month u_month (
    .doy   (s4_doy),
    .leap  (s4_leap),
    .month (month_c),
    .day   (day_c)
  );

  assign hour_c   = s4_hprod[25:21];
  assign rem_wide = s4_sod - 17'(hour_c) * 17'(SECS_PER_HOUR);

  // --------------------------------------------------------------------------
  // stage 6: minute by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [20:0] mprod_c;
  logic [11:0] s6_year;
  logic [3:0]  s6_month;
  logic [4:0]  s6_day;
  logic [4:0]  s6_hour;
  logic [11:0] s6_rem;
  logic [20:0] s6_mprod;
  logic        s6_neg;

  assign mprod_c = 21'(s5_rem[11:2]) * 21'(MIN_RECIP);

  // --------------------------------------------------------------------------
  // stage 7: minute, second, output register with range masking
  // --------------------------------------------------------------------------
  logic [5:0]  min_c;
  logic [11:0] sec_wide;

  assign min_c    = s6_mprod[19:14];
  assign sec_wide = s6_rem - 12'(min_c) * 12'(SECS_PER_MIN);

  // payload registers, loaded on advance, no reset needed
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_loc <= loc_next;
    end
    if (adv[2]) begin
      s2_prod <= prod_next;
      s2_hi   <= s1_loc[32:7];
      s2_lo   <= s1_loc[6:0];
      s2_neg  <= s1_loc[33];
    end
    if (adv[3]) begin
      s3_days <= days_c;
      s3_sod  <= {rem_hi[9:0], s2_lo};
      s3_est  <= est_prod[31:24];
      s3_neg  <= s2_neg;
    end
    if (adv[4]) begin
      s4_n     <= n_c;
      s4_doy   <= doy_wide[8:0];
      s4_leap  <= yr_leap(n_c);
      s4_sod   <= s3_sod;
      s4_hprod <= hprod_c;
      s4_neg   <= s3_neg;
    end
    if (adv[5]) begin
      s5_year  <= FIRST_YEAR + 12'(s4_n);
      s5_month <= month_c;
      s5_day   <= day_c;
      s5_hour  <= hour_c;
      s5_rem   <= rem_wide[11:0];
      s5_neg   <= s4_neg;
    end
    if (adv[6]) begin
      s6_year  <= s5_year;
      s6_month <= s5_month;
      s6_day   <= s5_day;
      s6_hour  <= s5_hour;
      s6_rem   <= s5_rem;
      s6_mprod <= mprod_c;
      s6_neg   <= s5_neg;
    end
    if (adv[7]) begin
      if (s6_neg) begin
        year         <= '0;
        month        <= '0;
        day          <= '0;
        hour         <= '0;
        minute       <= '0;
        second       <= '0;
        out_of_range <= 1'b1;
      end else begin
        year         <= s6_year;
        month        <= s6_month;
        day          <= s6_day;
        hour         <= s6_hour;
        minute       <= min_c;
        second       <= sec_wide[5:0];
        out_of_range <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/utlc_checker.sv]
// ----------------------------------------------------------------------------
// utlc_checker
// Port-level checks on the output words of the time-to-calendar block.
// ----------------------------------------------------------------------------
`default_nettype none

module utlc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] year,
  input wire logic [3:0]  month,
  input wire logic [4:0]  day,
  input wire logic [4:0]  hour,
  input wire logic [5:0]  minute,
  input wire logic [5:0]  second,
  input wire logic        out_of_range
);

  // flagged words carry no date or time
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |->
      year == 12'd0 && month == 4'd0 && day == 5'd0 &&
      hour == 5'd0 && minute == 6'd0 && second == 6'd0)
    else $error("out_of_range word with nonzero fields");

  // valid dates stay inside the calendar
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |->
      year >= 12'd1970 && year <= 12'd2106 &&
      month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31)
    else $error("date field out of range");

  // valid times stay inside the day
  a_time_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |->
      hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("time field out of range");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(year) && $stable(month) && $stable(day) &&
      $stable(hour) && $stable(minute) && $stable(second) && $stable(out_of_range))
    else $error("output word changed under stall");

endmodule

bind unix_time_to_local_calendar utlc_checker u_utlc_checker (.*);

`default_nettype wire
